/* sv/lease_address_allocator_assert.svh */
// ----------------------------------------------------------------------------
// lease_address_allocator_assert.svh
// assertion macros shared by the allocator rtl, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef LEASE_ADDRESS_ALLOCATOR_ASSERT_SVH
`define LEASE_ADDRESS_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LLA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LLA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lla_pkg.sv */
// ----------------------------------------------------------------------------
// lla_pkg
// widths, codes and types of the lease address allocator
// ----------------------------------------------------------------------------
package lla_pkg;

	// table and host space sizes
	localparam int MAX_LEASES = 128;
	localparam int HOST_BITS  = 8;
	localparam int HOST_SPAN  = 1 << HOST_BITS;
	localparam int LEASE_AW   = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;
	localparam int FILL_W     = $clog2(MAX_LEASES + 1);

	// field widths
	localparam int CODE_W     = 8;
	localparam int HW_W       = 48;
	localparam int XID_W      = 32;
	localparam int ADDR_W     = 32;
	localparam int OUT_HOST_W = 8;
	localparam int POOL_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// host scan counter holds the larger of pool and host width plus a carry bit
	localparam int CMP_W   = ((HOST_BITS > POOL_W) ? HOST_BITS : POOL_W) + 1;
	localparam int ENTRY_W = HW_W + HOST_BITS;

	localparam logic [CMP_W-1:0]     HOST_MAX = CMP_W'(HOST_SPAN - 1);
	localparam logic [FILL_W-1:0]    FILL_MAX = FILL_W'(MAX_LEASES);
	localparam logic [HOST_BITS-1:0] CLR_LAST = HOST_BITS'(HOST_SPAN - 1);

	// message codes
	localparam logic [CODE_W-1:0] BOOT_REQUEST  = 8'd1;
	localparam logic [CODE_W-1:0] OPT_MSG_TYPE  = 8'd53;
	localparam logic [CODE_W-1:0] KIND_DISCOVER = 8'd1;
	localparam logic [CODE_W-1:0] KIND_REQUEST  = 8'd3;

	// reply kinds
	localparam logic REPLY_OFFER = 1'b0;
	localparam logic REPLY_ACK   = 1'b1;

	// register reset values
	localparam logic [POOL_W-1:0] POOL_FIRST_RST  = 8'd100;
	localparam logic [POOL_W-1:0] POOL_LAST_RST   = 8'd200;
	localparam logic [ADDR_W-1:0] SUBNET_BASE_RST = 32'hC0A8_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_FIRST  = 2'd0,
		REG_POOL_LAST   = 2'd1,
		REG_SUBNET_BASE = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_ALLOC,
		ST_FINISH
	} lla_state_t;

	// sequencer controls
	typedef struct packed {
		logic req_ready;
		logic ram_we;
		logic issue;
		logic probe;
		logic clear;
		logic load_out;
	} lla_ctrl_t;

endpackage

/* sv/lla_if.sv */
// ----------------------------------------------------------------------------
// lla_if
// valid/ready channels of the lease address allocator
// ----------------------------------------------------------------------------

// decoded boot request
interface lla_req_if;
	logic                         valid;
	logic                         ready;
	logic [lla_pkg::CODE_W-1:0]   op_code;
	logic [lla_pkg::CODE_W-1:0]   first_option;
	logic [lla_pkg::CODE_W-1:0]   message_kind;
	logic [lla_pkg::HW_W-1:0]     client_hw;
	logic [lla_pkg::XID_W-1:0]    transaction_id;

	modport source (output valid, op_code, first_option, message_kind, client_hw,
		transaction_id, input ready);
	modport sink (input valid, op_code, first_option, message_kind, client_hw,
		transaction_id, output ready);
endinterface

// offer or ack reply
interface lla_rep_if;
	logic                             valid;
	logic                             ready;
	logic                             reply_kind;
	logic [lla_pkg::ADDR_W-1:0]       offered_addr;
	logic [lla_pkg::OUT_HOST_W-1:0]   assigned_host;
	logic                             pool_empty;
	logic [lla_pkg::XID_W-1:0]        reply_xid;
	logic [lla_pkg::HW_W-1:0]         reply_hw;

	modport source (output valid, reply_kind, offered_addr, assigned_host, pool_empty,
		reply_xid, reply_hw, input ready);
	modport sink (input valid, reply_kind, offered_addr, assigned_host, pool_empty,
		reply_xid, reply_hw, output ready);
endinterface

// register write channel
interface lla_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lla_pkg::CFG_IDX_W-1:0]    index;
	logic [lla_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/lla_ram.sv */
// ----------------------------------------------------------------------------
// lla_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/lease_address_allocator.sv */
// ----------------------------------------------------------------------------
// lease_address_allocator
// binds client hardware addresses to host numbers of a configured pool
// ----------------------------------------------------------------------------
//
// channel  dir  handshake     payload
// cfg      in   valid/ready   index, data (pool_first, pool_last, subnet_base)
// req      in   valid/ready   op_code, first_option, message_kind, client_hw,
//                             transaction_id
// rep      out  valid/ready   reply_kind, offered_addr, assigned_host,
//                             pool_empty, reply_xid, reply_hw
//
// one request at a time: accept, binding table walk through the table ram
// read port (none on an empty table), then for a new client a host map walk
// through the host ram, one host read per cycle and its check in the cycle
// after, then a finish state. a request that is not served is taken and the
// block stays idle. after reset a clearing pass zeroes the host map, req not
// ready. the reply sits in an output register; the finish state waits only
// while an earlier reply there is still not taken. cfg is always ready.
// ----------------------------------------------------------------------------
`include "lease_address_allocator_assert.svh"

module lease_address_allocator (
	input  logic      clk,
	input  logic      arst_n,
	lla_cfg_if.sink   cfg,
	lla_req_if.sink   req,
	lla_rep_if.source rep
);

	lla_pkg::lla_state_t state_q, state_d;
	lla_pkg::lla_ctrl_t  ctrl;

	// configuration
	logic [lla_pkg::POOL_W-1:0] pool_first_q;
	logic [lla_pkg::POOL_W-1:0] pool_last_q;
	logic [lla_pkg::ADDR_W-1:0] subnet_base_q;

	// request context
	logic [lla_pkg::CODE_W-1:0] kind_q;
	logic [lla_pkg::HW_W-1:0]   hw_q;
	logic [lla_pkg::XID_W-1:0]  xid_q;

	// walk state
	logic [lla_pkg::FILL_W-1:0]    fill_q;
	logic [lla_pkg::FILL_W-1:0]    scan_q;
	logic                          rd_pend_s1;
	logic [lla_pkg::CMP_W-1:0]     hscan_q;
	logic [lla_pkg::HOST_BITS-1:0] hchk_s1;
	logic                          hpend_s1;
	logic [lla_pkg::HOST_BITS-1:0] clr_q;
	logic [lla_pkg::HOST_BITS-1:0] host_q;
	logic                          empty_q;

	// reply register
	logic                              out_valid_q;
	logic                              out_kind_q;
	logic [lla_pkg::ADDR_W-1:0]        out_addr_q;
	logic [lla_pkg::OUT_HOST_W-1:0]    out_host_q;
	logic                              out_empty_q;
	logic [lla_pkg::XID_W-1:0]         out_xid_q;
	logic [lla_pkg::HW_W-1:0]          out_hw_q;

	logic                          req_acc;
	logic                          served;
	logic [lla_pkg::CMP_W-1:0]     top;
	logic                          hit;
	logic                          table_full;
	logic                          h_over;
	logic                          hit_free;
	logic                          reply_due;
	logic                          out_free;
	logic [lla_pkg::ENTRY_W-1:0]   rd_data;
	logic [lla_pkg::ENTRY_W-1:0]   wr_data;
	logic [lla_pkg::HW_W-1:0]      rd_key;
	logic [lla_pkg::HOST_BITS-1:0] rd_host;
	logic                          taken_rd;
	logic                          taken_we;
	logic [lla_pkg::HOST_BITS-1:0] taken_waddr;
	logic                          taken_wdata;

	// binding table: key and host of each lease, filled in order
	lla_ram #(
		.WIDTH (lla_pkg::ENTRY_W),
		.DEPTH (lla_pkg::MAX_LEASES)
	) u_table (
		.clk   (clk),
		.we    (ctrl.ram_we),
		.waddr (fill_q[lla_pkg::LEASE_AW-1:0]),
		.wdata (wr_data),
		.re    (ctrl.issue),
		.raddr (scan_q[lla_pkg::LEASE_AW-1:0]),
		.rdata (rd_data)
	);

	// host map: one taken bit per host number, zeroed by the clearing pass
	lla_ram #(
		.WIDTH (1),
		.DEPTH (lla_pkg::HOST_SPAN)
	) u_taken (
		.clk   (clk),
		.we    (taken_we),
		.waddr (taken_waddr),
		.wdata (taken_wdata),
		.re    (ctrl.probe),
		.raddr (hscan_q[lla_pkg::HOST_BITS-1:0]),
		.rdata (taken_rd)
	);

	assign wr_data     = {hw_q, hchk_s1};
	assign rd_key      = rd_data[lla_pkg::ENTRY_W-1 -: lla_pkg::HW_W];
	assign rd_host     = rd_data[lla_pkg::HOST_BITS-1:0];
	assign taken_we    = ctrl.clear || ctrl.ram_we;
	assign taken_waddr = ctrl.clear ? clr_q : hchk_s1;
	assign taken_wdata = !ctrl.clear;

	// status terms
	assign req_acc    = req.valid && req.ready;
	assign served     = (req.op_code == lla_pkg::BOOT_REQUEST) &&
		(req.first_option == lla_pkg::OPT_MSG_TYPE);
	assign top        = (lla_pkg::CMP_W'(pool_last_q) > lla_pkg::HOST_MAX) ?
		lla_pkg::HOST_MAX : lla_pkg::CMP_W'(pool_last_q);
	assign hit        = rd_pend_s1 && (rd_key == hw_q);
	assign table_full = (fill_q == lla_pkg::FILL_MAX);
	assign h_over     = (hscan_q > top);
	assign hit_free   = hpend_s1 && !taken_rd;
	assign reply_due  = (kind_q == lla_pkg::KIND_DISCOVER) ||
		(kind_q == lla_pkg::KIND_REQUEST);
	assign out_free   = !out_valid_q || rep.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lla_pkg::ST_CLEAR: begin
				if (clr_q == lla_pkg::CLR_LAST) begin
					state_d = lla_pkg::ST_IDLE;
				end
			end
			lla_pkg::ST_IDLE: begin
				if (req_acc && served) begin
					state_d = (fill_q == '0) ? lla_pkg::ST_ALLOC : lla_pkg::ST_LOOKUP;
				end
			end
			lla_pkg::ST_LOOKUP: begin
				if (hit) begin
					state_d = lla_pkg::ST_FINISH;
				end else if (scan_q == fill_q) begin
					state_d = lla_pkg::ST_ALLOC;
				end
			end
			lla_pkg::ST_ALLOC: begin
				if (table_full || h_over || hit_free) begin
					state_d = lla_pkg::ST_FINISH;
				end
			end
			lla_pkg::ST_FINISH: begin
				if (!reply_due || out_free) begin
					state_d = lla_pkg::ST_IDLE;
				end
			end
			default: state_d = lla_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl.req_ready = (state_q == lla_pkg::ST_IDLE);
		ctrl.ram_we    = (state_q == lla_pkg::ST_ALLOC) && !table_full && hit_free;
		ctrl.issue     = (state_q == lla_pkg::ST_LOOKUP) && (scan_q < fill_q);
		ctrl.probe     = (state_q == lla_pkg::ST_ALLOC) && !table_full && !h_over;
		ctrl.clear     = (state_q == lla_pkg::ST_CLEAR);
		ctrl.load_out  = (state_q == lla_pkg::ST_FINISH) && reply_due && out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lla_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_first_q  <= lla_pkg::POOL_FIRST_RST;
			pool_last_q   <= lla_pkg::POOL_LAST_RST;
			subnet_base_q <= lla_pkg::SUBNET_BASE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				lla_pkg::REG_POOL_FIRST:  pool_first_q  <= cfg.data[lla_pkg::POOL_W-1:0];
				lla_pkg::REG_POOL_LAST:   pool_last_q   <= cfg.data[lla_pkg::POOL_W-1:0];
				lla_pkg::REG_SUBNET_BASE: subnet_base_q <= cfg.data[lla_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// table walk, host map clearing and lease bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			scan_q     <= '0;
			rd_pend_s1 <= 1'b0;
			hpend_s1   <= 1'b0;
			clr_q      <= '0;
		end else begin
			rd_pend_s1 <= ctrl.issue;
			hpend_s1   <= ctrl.probe;
			if (req_acc) begin
				scan_q <= '0;
			end else if (ctrl.issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (ctrl.ram_we) begin
				fill_q <= fill_q + 1'b1;
			end
			if (ctrl.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// request context and host walk
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q  <= req.message_kind;
			hw_q    <= req.client_hw;
			xid_q   <= req.transaction_id;
			hscan_q <= lla_pkg::CMP_W'(pool_first_q);
		end else if (state_q == lla_pkg::ST_LOOKUP && hit) begin
			host_q  <= rd_host;
			empty_q <= 1'b0;
		end else if (state_q == lla_pkg::ST_ALLOC) begin
			if (ctrl.probe) begin
				hscan_q <= hscan_q + 1'b1;
				hchk_s1 <= hscan_q[lla_pkg::HOST_BITS-1:0];
			end
			if (table_full || (h_over && !hit_free)) begin
				host_q  <= '0;
				empty_q <= 1'b1;
			end else if (hit_free) begin
				host_q  <= hchk_s1;
				empty_q <= 1'b0;
			end
		end
	end

	// reply valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rep.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// reply payload
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_kind_q  <= (kind_q == lla_pkg::KIND_REQUEST) ?
				lla_pkg::REPLY_ACK : lla_pkg::REPLY_OFFER;
			out_addr_q  <= empty_q ? '0 : subnet_base_q + lla_pkg::ADDR_W'(host_q);
			out_host_q  <= lla_pkg::OUT_HOST_W'(host_q);
			out_empty_q <= empty_q;
			out_xid_q   <= xid_q;
			out_hw_q    <= hw_q;
		end
	end

	assign cfg.ready         = 1'b1;
	assign req.ready         = ctrl.req_ready;
	assign rep.valid         = out_valid_q;
	assign rep.reply_kind    = out_kind_q;
	assign rep.offered_addr  = out_addr_q;
	assign rep.assigned_host = out_host_q;
	assign rep.pool_empty    = out_empty_q;
	assign rep.reply_xid     = out_xid_q;
	assign rep.reply_hw      = out_hw_q;

	// checks
	`LLA_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= lla_pkg::FILL_MAX, "binding fill over table size")
	`LLA_ASSERT_NEXT(a_fill_only_alloc, state_q != lla_pkg::ST_ALLOC, $stable(fill_q), "fill moved outside allocation")
	`LLA_ASSERT_NOW(a_empty_zero, rep.valid && rep.pool_empty, rep.offered_addr == '0 && rep.assigned_host == '0, "exhausted reply carries an address")
	`LLA_ASSERT_NEXT(a_load_sets_valid, ctrl.load_out, rep.valid, "loaded reply not presented")

endmodule

/* test/lease_address_allocator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lease_address_allocator_checker
// watches the register, request and reply channels of the allocator, keeps
// its own binding table, host map and pool registers, works out the reply
// of each served discover/request, compares each reply field by field, in order
// ----------------------------------------------------------------------------
module lease_address_allocator_checker
	import lla_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lla_cfg_if   cfg,
	lla_req_if   req,
	lla_rep_if   rep,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic                  kind;
		logic [ADDR_W-1:0]     addr;
		logic [OUT_HOST_W-1:0] host;
		logic                  empty;
		logic [XID_W-1:0]      xid;
		logic [HW_W-1:0]       hw;
	} lease_reply_t;

	// shadow of the pool registers
	logic [POOL_W-1:0]    pool_lo;
	logic [POOL_W-1:0]    pool_hi;
	logic [ADDR_W-1:0]    net_base;

	// shadow binding table and host map
	logic [HW_W-1:0]      lease_key  [MAX_LEASES];
	logic [HOST_BITS-1:0] lease_host [MAX_LEASES];
	logic                 lease_live [MAX_LEASES];
	logic                 host_busy  [HOST_SPAN];
	int                   lease_count;

	lease_reply_t         reply_q[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// binds the client if new and builds its reply; returns 1 when a reply is due
	function automatic logic bind_and_reply(input logic [CODE_W-1:0] kind,
		input logic [HW_W-1:0] hw, input logic [XID_W-1:0] xid, output lease_reply_t rsp);
		logic hit;
		logic exhausted;
		int   host;
		int   top;
		hit       = 1'b0;
		exhausted = 1'b0;
		host      = 0;

		// existing binding keeps its host
		for (int i = 0; i < MAX_LEASES; i++)
			if (!hit && lease_live[i] && lease_key[i] == hw) begin
				hit  = 1'b1;
				host = int'(lease_host[i]);
			end

		// new client: lowest free host in the pool, if the table has room
		if (!hit) begin
			top = (int'(pool_hi) > HOST_SPAN - 1) ? HOST_SPAN - 1 : int'(pool_hi);
			if (lease_count < MAX_LEASES)
				for (int h = int'(pool_lo); h <= top; h++)
					if (!hit && !host_busy[h]) begin
						hit  = 1'b1;
						host = h;
					end
			if (hit) begin
				lease_key[lease_count]  = hw;
				lease_host[lease_count] = HOST_BITS'(host);
				lease_live[lease_count] = 1'b1;
				lease_count++;
				host_busy[host] = 1'b1;
			end else begin
				host      = 0;
				exhausted = 1'b1;
			end
		end

		rsp.kind  = (kind == KIND_REQUEST) ? REPLY_ACK : REPLY_OFFER;
		rsp.addr  = exhausted ? '0 : net_base + ADDR_W'(host);
		rsp.host  = OUT_HOST_W'(host);
		rsp.empty = exhausted;
		rsp.xid   = xid;
		rsp.hw    = hw;
		return (kind == KIND_DISCOVER) || (kind == KIND_REQUEST);
	endfunction

	// register writes, request prediction and reply compare
	always @(posedge clk or negedge arst_n) begin : watch
		lease_reply_t want;
		if (!arst_n) begin
			mismatches  = 0;
			pool_lo     = POOL_FIRST_RST;
			pool_hi     = POOL_LAST_RST;
			net_base    = SUBNET_BASE_RST;
			lease_count = 0;
			for (int i = 0; i < MAX_LEASES; i++)
				lease_live[i] = 1'b0;
			for (int h = 0; h < HOST_SPAN; h++)
				host_busy[h] = 1'b0;
			reply_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_POOL_FIRST:  pool_lo  = cfg.data[POOL_W-1:0];
					REG_POOL_LAST:   pool_hi  = cfg.data[POOL_W-1:0];
					REG_SUBNET_BASE: net_base = cfg.data[ADDR_W-1:0];
					default: ;
				endcase
			end

			// only boot requests that start with the message type option are served
			if (req.valid && req.ready && req.op_code == BOOT_REQUEST &&
				req.first_option == OPT_MSG_TYPE) begin
				if (bind_and_reply(req.message_kind, req.client_hw, req.transaction_id, want))
					reply_q.push_back(want);
			end

			if (rep.valid && rep.ready) begin
				if (reply_q.size() == 0) begin
					report_mismatch("reply with none expected, xid", 64'(rep.reply_xid), '0);
				end else begin
					want = reply_q.pop_front();
					if (rep.reply_kind !== want.kind)
						report_mismatch("reply_kind", 64'(rep.reply_kind), 64'(want.kind));
					if (rep.offered_addr !== want.addr)
						report_mismatch("offered_addr", 64'(rep.offered_addr), 64'(want.addr));
					if (rep.assigned_host !== want.host)
						report_mismatch("assigned_host", 64'(rep.assigned_host),
							64'(want.host));
					if (rep.pool_empty !== want.empty)
						report_mismatch("pool_empty", 64'(rep.pool_empty), 64'(want.empty));
					if (rep.reply_xid !== want.xid)
						report_mismatch("reply_xid", 64'(rep.reply_xid), 64'(want.xid));
					if (rep.reply_hw !== want.hw)
						report_mismatch("reply_hw", 64'(rep.reply_hw), 64'(want.hw));
				end
			end
			outstanding <= reply_q.size();
		end
	end

endmodule

/* test/lease_address_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lease_address_allocator_tb
// drives directed and random boot requests through several pool settings,
// with random gaps on the request side and random stalls on the reply side;
// the checker beside the block predicts and compares every reply
// ----------------------------------------------------------------------------
module lease_address_allocator_tb;
	import lla_pkg::*;

	// worst busy time is a table walk, a full host walk and the finish state
	localparam int SETTLE_CYCLES = 600;
	localparam int GAP_MAX       = 7;
	localparam int RUN_LIMIT_NS  = 20_000_000;

	logic clk;
	logic arst_n;
	logic send_calm;
	logic take_calm;
	int   mismatches;
	int   outstanding;

	logic [HW_W-1:0] known_hw[$];

	lla_cfg_if cfg_ch ();
	lla_req_if req_ch ();
	lla_rep_if rep_ch ();

	lease_address_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rep    (rep_ch)
	);

	lease_address_allocator_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.req         (req_ch),
		.rep         (rep_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	// reply side: random stall before each reply is taken
	initial begin : reply_sink
		int stall;
		rep_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = take_calm ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				rep_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rep_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rep_ch.valid) @(posedge clk);
		end
	end

	// one request, after a random gap; valid stays high on return
	task automatic send_item(input logic [CODE_W-1:0] op, input logic [CODE_W-1:0] opt,
		input logic [CODE_W-1:0] kind, input logic [HW_W-1:0] hw,
		input logic [XID_W-1:0] xid);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.op_code        <= op;
		req_ch.first_option   <= opt;
		req_ch.message_kind   <= kind;
		req_ch.client_hw      <= hw;
		req_ch.transaction_id <= xid;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// stop sending, wait for every reply, then let the block finish its walk
	task automatic drain(input int extra);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// writes all three pool registers back to back, junk in unused data bits
	task automatic program_pool(input logic [POOL_W-1:0] first,
		input logic [POOL_W-1:0] last, input logic [ADDR_W-1:0] base);
		cfg_reg_t                regs [3];
		logic [CFG_DATA_W-1:0]   vals [3];
		regs[0] = REG_POOL_FIRST;
		regs[1] = REG_POOL_LAST;
		regs[2] = REG_SUBNET_BASE;
		vals[0] = {24'($urandom), first};
		vals[1] = {24'($urandom), last};
		vals[2] = base;
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[i];
			cfg_ch.data  <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// a fresh client or one seen before
	function automatic logic [HW_W-1:0] pick_client(input int new_pct);
		logic [HW_W-1:0] hw;
		if (known_hw.size() == 0 || $urandom_range(0, 99) < new_pct) begin
			hw = {16'($urandom), 32'($urandom)};
			known_hw.push_back(hw);
		end else begin
			hw = known_hw[$urandom_range(0, known_hw.size() - 1)];
		end
		return hw;
	endfunction

	// mostly well-formed discover/request, some noise and broken headers
	task automatic send_random(input int new_pct, output logic served);
		logic [CODE_W-1:0] op;
		logic [CODE_W-1:0] opt;
		logic [CODE_W-1:0] kind;
		int                pick;
		pick = $urandom_range(0, 99);
		op   = BOOT_REQUEST;
		opt  = OPT_MSG_TYPE;
		kind = $urandom_range(0, 1) ? KIND_DISCOVER : KIND_REQUEST;
		if (pick < 10) begin
			op   = 8'($urandom);
			opt  = 8'($urandom);
			kind = 8'($urandom);
		end else if (pick < 13) begin
			op = BOOT_REQUEST ^ 8'($urandom_range(1, 255));
		end else if (pick < 16) begin
			opt = OPT_MSG_TYPE ^ 8'($urandom_range(1, 255));
		end else if (pick < 24) begin
			kind = 8'($urandom);
		end
		served = (op == BOOT_REQUEST) && (opt == OPT_MSG_TYPE);
		send_item(op, opt, kind, pick_client(new_pct), 32'($urandom));
	endtask

	// random phase; pauses for all replies halfway through
	task automatic run_random(input int count, input int new_pct);
		int   served;
		logic hit;
		served = 0;
		while (served < count) begin
			send_random(new_pct, hit);
			if (hit) begin
				served++;
				if (served == count / 2)
					drain(0);
			end
		end
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [HW_W-1:0] hw_a;
		logic [HW_W-1:0] hw_b;
		logic [HW_W-1:0] hw_c;
		logic [HW_W-1:0] hw_d;
		logic [HW_W-1:0] hw_e;
		arst_n                 = 1'b0;
		send_calm              = 1'b0;
		take_calm              = 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= REG_POOL_FIRST;
		cfg_ch.data           <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.op_code        <= '0;
		req_ch.first_option   <= '0;
		req_ch.message_kind   <= '0;
		req_ch.client_hw      <= '0;
		req_ch.transaction_id <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		hw_a = '0;
		hw_b = '1;
		hw_c = 48'h0000_0000_1234;
		hw_d = 48'h0A0B_0C0D_0E0F;
		hw_e = 48'h8000_0000_0001;
		known_hw.push_back(hw_a);
		known_hw.push_back(hw_b);
		known_hw.push_back(hw_c);

		// directed, reset pool: wrong opcode or first option is ignored
		send_item(8'd0,         OPT_MSG_TYPE, KIND_DISCOVER, hw_d, 32'h1);
		send_item(8'hFF,        OPT_MSG_TYPE, KIND_REQUEST,  hw_d, 32'h2);
		send_item(BOOT_REQUEST, 8'd0,         KIND_DISCOVER, hw_d, 32'h3);
		send_item(BOOT_REQUEST, 8'hFF,        KIND_DISCOVER, hw_d, 32'h4);
		// offer then ack for the same client, field extremes
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, KIND_DISCOVER, hw_a, 32'h0);
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, KIND_REQUEST,  hw_a, 32'hFFFF_FFFF);
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, KIND_DISCOVER, hw_b, 32'hA5A5_5A5A);
		// other message kinds bind silently
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, 8'd0,          hw_c, 32'h5);
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, KIND_DISCOVER, hw_c, 32'h6);
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, 8'hFF,         hw_e, 32'h7);
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, 8'd2,          ~hw_e, 32'h8);
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, KIND_REQUEST,  hw_e, 32'h9);
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, KIND_REQUEST,  hw_b, 32'h5A5A_A5A5);
		// ignored request must not have bound this client
		send_item(BOOT_REQUEST, OPT_MSG_TYPE, KIND_DISCOVER, hw_d, 32'hA);
		drain(SETTLE_CYCLES);

		// tiny pool: runs out of hosts
		program_pool(8'd10, 8'd12, 32'h0);
		run_random(90, 50);
		drain(SETTLE_CYCLES);

		// empty range, address wraps for bound clients
		program_pool(8'd200, 8'd100, 32'hFFFF_FFFF);
		run_random(90, 30);
		drain(SETTLE_CYCLES);

		// top host only, no idling on either side
		send_calm = 1'b1;
		take_calm = 1'b1;
		program_pool(8'd255, 8'd255, 32'h0A00_0000);
		run_random(90, 30);
		drain(SETTLE_CYCLES);

		// host zero only
		send_calm = 1'b0;
		program_pool(8'd0, 8'd0, 32'($urandom));
		run_random(90, 30);
		drain(SETTLE_CYCLES);
		take_calm = 1'b0;

		// full host range: fills the binding table
		program_pool(8'd0, 8'd255, 32'($urandom));
		run_random(340, 40);
		drain(SETTLE_CYCLES);

		// upper half, table full by now
		program_pool(8'd128, 8'd255, 32'($urandom));
		run_random(320, 40);
		drain(SETTLE_CYCLES);

		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/lla_pkg.sv
sv/lla_if.sv
sv/lla_ram.sv
sv/lease_address_allocator.sv
test/lease_address_allocator_checker.sv
test/lease_address_allocator_tb.sv
